/* rtl/afr_pkg.sv */
// ----------------------------------------------------------------------------
// afr_pkg
// Shared constants, types and helpers of the audio frame ring with crossfade.
// ----------------------------------------------------------------------------
package afr_pkg;

	localparam int FRAME_SLOTS = 8;
	localparam int MAX_FRAME   = 1024;

	localparam int SLOT_W   = $clog2(FRAME_SLOTS);
	localparam int POS_W    = $clog2(MAX_FRAME);
	localparam int CNT_W    = $clog2(MAX_FRAME + 1);
	localparam int FS_DEPTH = FRAME_SLOTS * MAX_FRAME;
	localparam int FS_AW    = $clog2(FS_DEPTH);

	localparam int LEN_W     = 11;
	localparam int STEP_W    = 15;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 2;
	localparam int FC_W      = 16;
	localparam int FADE_W    = 26;
	localparam int W2_W      = FADE_W - 8;
	localparam int SMP_W     = 16;
	localparam int ENT_W     = 2 * SMP_W;
	localparam int DIFF_W    = SMP_W + 1;
	localparam int MUL_W     = DIFF_W + W2_W + 1;
	localparam int SUM_W     = MUL_W - 7;

	// slot of the count just below zero, i.e. 0xFFFF modulo the ring size
	localparam logic [SLOT_W-1:0] WRAP_SLOT = SLOT_W'(65535 % FRAME_SLOTS);

	localparam logic [LEN_W-1:0]  FRAME_LENGTH_RST = LEN_W'(736);
	localparam logic [STEP_W-1:0] MIX_STEP_RST     = STEP_W'(178);

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MIX_STEP     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE  = CFG_IDX_W'(2);

	typedef logic signed [SMP_W-1:0] sample_t;

	typedef enum logic [1:0] {
		MODE_WRITE   = 2'd0,
		MODE_READ    = 2'd1,
		MODE_RESTART = 2'd2,
		MODE_NOP     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CASE_MIRROR = 2'd0,
		CASE_COPY   = 2'd1,
		CASE_FADE   = 2'd2
	} case_t;

	typedef enum logic [1:0] {
		RGN_OLD,
		RGN_MIX,
		RGN_NEW
	} region_t;

	// control carried alongside a read word in the first pipeline stage
	typedef struct packed {
		case_t             fcase;
		region_t           region;
		logic [POS_W-1:0]  pos;
		logic              fend;
		logic              mono;
		logic [W2_W-1:0]   w2;
	} rd_ctl_t;

	function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] fl);
		int n;
		n = int'({fl[LEN_W-1:2], 2'b00});
		if (n < 4) n = 4;
		if (n > MAX_FRAME) n = MAX_FRAME & ~3;
		return CNT_W'(n);
	endfunction

	function automatic logic [FS_AW-1:0] fs_addr(input logic [SLOT_W-1:0] slot,
			input logic [POS_W-1:0] pos);
		return FS_AW'(slot) * FS_AW'(MAX_FRAME) + FS_AW'(pos);
	endfunction

	// slot of count+1, given the slot of count
	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot,
			input logic [FC_W-1:0] count);
		logic [SLOT_W-1:0] r;
		if (count == '1) r = '0;
		else if (slot == SLOT_W'(FRAME_SLOTS - 1)) r = '0;
		else r = slot + 1'b1;
		return r;
	endfunction

	function automatic logic [SMP_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
		logic [SMP_W-1:0] r;
		if (v[SUM_W-1:SMP_W-1] == '0 || v[SUM_W-1:SMP_W-1] == '1) r = v[SMP_W-1:0];
		else if (v[SUM_W-1]) r = {1'b1, {(SMP_W-1){1'b0}}};
		else r = {1'b0, {(SMP_W-1){1'b1}}};
		return r;
	endfunction

endpackage

/* rtl/afr_in_if.sv */
// ----------------------------------------------------------------------------
// afr_in_if
// Request channel: write, read, restart and idle words with their sample payload.
// ----------------------------------------------------------------------------
interface afr_in_if import afr_pkg::*; ();
	logic    valid;
	logic    ready;
	mode_t   mode;
	sample_t left_in;
	sample_t right_in;

	modport source (output valid, output mode, output left_in, output right_in,
		input ready);
	modport sink (input valid, input mode, input left_in, input right_in,
		output ready);
endinterface

/* rtl/afr_out_if.sv */
// ----------------------------------------------------------------------------
// afr_out_if
// Result channel: one output sample word per read request.
// ----------------------------------------------------------------------------
interface afr_out_if import afr_pkg::*; ();
	logic       valid;
	logic       ready;
	sample_t    left_out;
	sample_t    right_out;
	logic [1:0] frame_case;
	logic       frame_end;

	modport source (output valid, output left_out, output right_out,
		output frame_case, output frame_end, input ready);
	modport sink (input valid, input left_out, input right_out,
		input frame_case, input frame_end, output ready);
endinterface

/* rtl/afr_ram.sv */
// ----------------------------------------------------------------------------
// afr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module afr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data when no read is issued
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/audio_frame_ring_with_crossfade_top.sv */
// ----------------------------------------------------------------------------
// audio_frame_ring_with_crossfade_top
// Eight-frame sample ring with mirror, copy and crossfade playout.
// ----------------------------------------------------------------------------
// Pipeline: memory read (stage 1), stage 2, output register; all hold on a result stall.
// Throughput: one word per cycle while results are taken; a mirror frame start
//   holds ready low while the tail of the previous frame is written back to the
//   previous-output memory (frame store and history share no read port).
// Reset: counters and registers clear at once, then a clearing pass over all
//   FRAME_SLOTS*MAX_FRAME (8192) frame-store addresses zeroes both memories with
//   ready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module audio_frame_ring_with_crossfade_top import afr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	afr_in_if.sink               req,
	afr_out_if.source            rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [LEN_W-1:0]  frame_length_q;
	logic [STEP_W-1:0] mix_step_q;
	logic              stereo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= FRAME_LENGTH_RST;
			mix_step_q     <= MIX_STEP_RST;
			stereo_q       <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_FRAME_LENGTH: frame_length_q <= cfg_data[LEN_W-1:0];
				REG_MIX_STEP:     mix_step_q     <= cfg_data[STEP_W-1:0];
				REG_STEREO_MODE:  stereo_q       <= cfg_data[0];
				default: begin
					// index beyond the register list: drop the write
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Ring state
	// ------------------------------------------------------------------
	logic [FC_W-1:0]   wfc_q, rfc_q;        // write and read frame counts
	logic [SLOT_W-1:0] wslot_q, rslot_q;    // the counts modulo FRAME_SLOTS
	logic [SLOT_W-1:0] oldest_q, newest_q;  // slots latched at frame start
	logic [CNT_W-1:0]  fill_q, opos_q;
	case_t             lcase_q;
	logic [FADE_W-1:0] fade_q;
	logic              clr_q;
	logic [FS_AW-1:0]  clr_cnt_q;

	// ------------------------------------------------------------------
	// Issue stage: decide the frame case and address the memories
	// ------------------------------------------------------------------
	logic [CNT_W-1:0]  len, half, quarter, pos0, pos_inc, pos_nxt, fill_inc;
	logic [FC_W-1:0]   diff;
	logic              start, fend;
	case_t             dcase, cur_case;
	region_t           region;
	logic [SLOT_W-1:0] newest_calc, rd_old, rd_new;
	logic [FADE_W-1:0] fw_cur;
	logic [POS_W-1:0]  maddr;

	always_comb begin
		len      = eff_len(frame_length_q);
		half     = len >> 1;
		quarter  = len >> 2;
		// a shortened frame length restarts the output frame
		pos0     = (opos_q >= len) ? '0 : opos_q;
		start    = (pos0 == '0);
		diff     = wfc_q - rfc_q;

		priority if (diff[FC_W-1] || diff == '0) begin
			dcase = CASE_MIRROR;
		end else if (diff <= FC_W'(3)) begin
			dcase = CASE_COPY;
		end else begin
			dcase = CASE_FADE;
		end
		cur_case = start ? dcase : lcase_q;

		// slot of write count minus one
		if (wfc_q == '0) newest_calc = WRAP_SLOT;
		else if (wslot_q == '0) newest_calc = SLOT_W'(FRAME_SLOTS - 1);
		else newest_calc = wslot_q - 1'b1;

		rd_old = start ? rslot_q : oldest_q;
		rd_new = (start && dcase == CASE_FADE) ? newest_calc : newest_q;
		fw_cur = start ? '0 : fade_q;

		priority if (pos0 < quarter) begin
			region = RGN_OLD;
		end else if (pos0 < quarter + half) begin
			region = RGN_MIX;
		end else begin
			region = RGN_NEW;
		end

		// mirror: first half runs backwards over the previous frame's tail
		if (pos0 < half) maddr = POS_W'(len - 1'b1 - pos0);
		else maddr = pos0[POS_W-1:0];

		fend     = (pos0 == len - 1'b1);
		pos_inc  = pos0 + 1'b1;
		pos_nxt  = (pos_inc >= len) ? '0 : pos_inc;
		fill_inc = fill_q + 1'b1;
	end

	// ------------------------------------------------------------------
	// Handshake and pipeline flow
	// ------------------------------------------------------------------
	logic              v_s1, v_s2, out_v_q;
	rd_ctl_t           ctl_s1;
	logic [POS_W-1:0]  pos_s2;
	logic              out_ok, s2_ok, s1_ok, hazard;
	logic              acc, is_wr, is_rd, is_rst;

	assign out_ok = !out_v_q || rsp.ready;
	assign s2_ok  = !v_s2 || out_ok;
	assign s1_ok  = !v_s1 || s2_ok;

	// history entries of the two words still in flight are not yet written
	assign hazard = (cur_case == CASE_MIRROR) &&
		((v_s1 && ctl_s1.pos == maddr) || (v_s2 && pos_s2 == maddr));

	assign req.ready = !clr_q && s1_ok && !hazard;
	assign acc    = req.valid && req.ready;
	assign is_wr  = acc && (req.mode == MODE_WRITE);
	assign is_rd  = acc && (req.mode == MODE_READ);
	assign is_rst = acc && (req.mode == MODE_RESTART);

	// ------------------------------------------------------------------
	// Counter and latch updates
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wfc_q     <= '0;
			rfc_q     <= '0;
			wslot_q   <= '0;
			rslot_q   <= '0;
			oldest_q  <= '0;
			newest_q  <= '0;
			fill_q    <= '0;
			opos_q    <= '0;
			lcase_q   <= CASE_MIRROR;
			fade_q    <= '0;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == FS_AW'(FS_DEPTH - 1)) begin
					clr_q <= 1'b0;
				end
			end

			if (is_wr) begin
				// advance the write frame once it is full
				if (fill_inc >= len) begin
					fill_q  <= '0;
					wfc_q   <= wfc_q + 1'b1;
					wslot_q <= slot_inc(wslot_q, wfc_q);
				end else begin
					fill_q  <= fill_inc;
				end
			end

			if (is_rst) begin
				wfc_q   <= '0;
				rfc_q   <= '0;
				wslot_q <= '0;
				rslot_q <= '0;
				fill_q  <= '0;
				opos_q  <= '0;
				fade_q  <= '0;
			end

			if (is_rd) begin
				opos_q <= pos_nxt;
				if (cur_case == CASE_FADE && region == RGN_MIX) begin
					fade_q <= fw_cur + FADE_W'(mix_step_q);
				end else begin
					fade_q <= fw_cur;
				end
				if (start) begin
					lcase_q <= dcase;
					unique case (dcase)
						CASE_COPY: begin
							oldest_q <= rslot_q;
							rfc_q    <= rfc_q + 1'b1;
							rslot_q  <= slot_inc(rslot_q, rfc_q);
						end
						CASE_FADE: begin
							// catch up: skip every pending frame
							oldest_q <= rslot_q;
							newest_q <= newest_calc;
							rfc_q    <= wfc_q;
							rslot_q  <= wslot_q;
						end
						default: begin
							// mirror: leave the read side alone
						end
					endcase
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Memories: frame store twice over (oldest and newest read at once),
	// previous-output history once
	// ------------------------------------------------------------------
	logic             fs_we, po_we;
	logic [FS_AW-1:0] fs_waddr;
	logic [ENT_W-1:0] fs_wdata, po_wdata;
	logic [POS_W-1:0] po_waddr;
	logic [ENT_W-1:0] fs_a_rd, fs_b_rd, po_rd;
	logic [ENT_W-1:0] entry_s2;

	always_comb begin
		fs_we    = clr_q || is_wr;
		fs_waddr = clr_q ? clr_cnt_q : fs_addr(wslot_q, fill_q[POS_W-1:0]);
		fs_wdata = clr_q ? '0 :
			{(stereo_q ? req.right_in : sample_t'(0)), req.left_in};

		po_we    = (clr_q && clr_cnt_q < FS_AW'(MAX_FRAME)) || (v_s2 && out_ok);
		po_waddr = clr_q ? clr_cnt_q[POS_W-1:0] : pos_s2;
		po_wdata = clr_q ? '0 : entry_s2;
	end

	afr_ram #(.WIDTH(ENT_W), .DEPTH(FS_DEPTH)) u_fs_old (
		.clk   (clk),
		.we    (fs_we),
		.waddr (fs_waddr),
		.wdata (fs_wdata),
		.re    (is_rd),
		.raddr (fs_addr(rd_old, pos0[POS_W-1:0])),
		.rdata (fs_a_rd)
	);

	afr_ram #(.WIDTH(ENT_W), .DEPTH(FS_DEPTH)) u_fs_new (
		.clk   (clk),
		.we    (fs_we),
		.waddr (fs_waddr),
		.wdata (fs_wdata),
		.re    (is_rd),
		.raddr (fs_addr(rd_new, pos0[POS_W-1:0])),
		.rdata (fs_b_rd)
	);

	afr_ram #(.WIDTH(ENT_W), .DEPTH(MAX_FRAME)) u_prev (
		.clk   (clk),
		.we    (po_we),
		.waddr (po_waddr),
		.wdata (po_wdata),
		.re    (is_rd),
		.raddr (maddr),
		.rdata (po_rd)
	);

	// ------------------------------------------------------------------
	// Stage 1: memory data returns; select source, multiply fade deltas
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_ok) begin
			v_s1 <= is_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (is_rd) begin
			ctl_s1.fcase  <= cur_case;
			ctl_s1.region <= region;
			ctl_s1.pos    <= pos0[POS_W-1:0];
			ctl_s1.fend   <= fend;
			ctl_s1.mono   <= !stereo_q;
			ctl_s1.w2     <= fw_cur[FADE_W-1:8];
		end
	end

	logic [ENT_W-1:0]         base_s1;
	logic                     mix_sel_s1;
	logic signed [DIFF_W-1:0] dl_s1, dr_s1;
	logic signed [W2_W:0]     wsg_s1;
	logic signed [MUL_W-1:0]  prodl_s1, prodr_s1;

	always_comb begin
		unique case (ctl_s1.fcase)
			CASE_MIRROR: base_s1 = po_rd;
			CASE_COPY:   base_s1 = fs_a_rd;
			default:     base_s1 = (ctl_s1.region == RGN_NEW) ? fs_b_rd : fs_a_rd;
		endcase
		mix_sel_s1 = (ctl_s1.fcase == CASE_FADE) && (ctl_s1.region == RGN_MIX);

		// a*(256-w) + b*w == 256*a + (b-a)*w
		dl_s1    = DIFF_W'($signed(fs_b_rd[SMP_W-1:0])) -
			DIFF_W'($signed(fs_a_rd[SMP_W-1:0]));
		dr_s1    = DIFF_W'($signed(fs_b_rd[ENT_W-1:SMP_W])) -
			DIFF_W'($signed(fs_a_rd[ENT_W-1:SMP_W]));
		wsg_s1   = $signed({1'b0, ctl_s1.w2});
		prodl_s1 = dl_s1 * wsg_s1;
		prodr_s1 = dr_s1 * wsg_s1;
	end

	// ------------------------------------------------------------------
	// Stage 2: add, floor, saturate; write history
	// ------------------------------------------------------------------
	logic                    mix_s2, end_s2, mono_s2;
	case_t                   case_s2;
	logic [ENT_W-1:0]        ent_s2;
	logic signed [MUL_W-1:0] prodl_s2, prodr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_ok) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ok && v_s1) begin
			mix_s2   <= mix_sel_s1;
			ent_s2   <= base_s1;
			prodl_s2 <= prodl_s1;
			prodr_s2 <= prodr_s1;
			pos_s2   <= ctl_s1.pos;
			case_s2  <= ctl_s1.fcase;
			end_s2   <= ctl_s1.fend;
			mono_s2  <= ctl_s1.mono;
		end
	end

	logic [SMP_W-1:0] mixl_s2, mixr_s2;

	always_comb begin
		mixl_s2 = sat16(SUM_W'($signed(ent_s2[SMP_W-1:0])) + SUM_W'(prodl_s2 >>> 8));
		mixr_s2 = sat16(SUM_W'($signed(ent_s2[ENT_W-1:SMP_W])) + SUM_W'(prodr_s2 >>> 8));
		entry_s2 = mix_s2 ? {mixr_s2, mixl_s2} : ent_s2;
		// mono: drop the right half everywhere, history included
		if (mono_s2) begin
			entry_s2[ENT_W-1:SMP_W] = '0;
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic [ENT_W-1:0] out_ent_q;
	case_t            out_case_q;
	logic             out_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_ok) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ok && v_s2) begin
			out_ent_q  <= entry_s2;
			out_case_q <= case_s2;
			out_end_q  <= end_s2;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.left_out   = out_ent_q[SMP_W-1:0];
	assign rsp.right_out  = out_ent_q[ENT_W-1:SMP_W];
	assign rsp.frame_case = out_case_q;
	assign rsp.frame_end  = out_end_q;

endmodule

/* rtl/afr_checker.sv */
// ----------------------------------------------------------------------------
// afr_checker
// Port-level checks on the frame ring, bound to the top level.
// ----------------------------------------------------------------------------
module afr_checker import afr_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [SMP_W-1:0]     rsp_left_out,
	input logic [SMP_W-1:0]     rsp_right_out,
	input logic [1:0]           rsp_frame_case,
	input logic                 rsp_frame_end,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic                 cfg_stereo_bit
);
	// shadow of the stereo register, taken from the write port
	logic stereo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_q <= 1'b1;
		end else if (cfg_we && cfg_idx == REG_STEREO_MODE) begin
			stereo_q <= cfg_stereo_bit;
		end
	end

	// a stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_out) &&
			$stable(rsp_right_out) && $stable(rsp_frame_case) && $stable(rsp_frame_end))
		else $error("result word changed while stalled");

	// clearing pass keeps the request side closed right after reset
	a_clear_closed: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !req_ready)
		else $error("request accepted before memories were cleared");

	// mono playout carries no right channel
	a_mono_right: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !stereo_q |-> rsp_right_out == '0)
		else $error("right sample non-zero in mono");

endmodule

bind audio_frame_ring_with_crossfade_top afr_checker u_afr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_left_out   (rsp.left_out),
	.rsp_right_out  (rsp.right_out),
	.rsp_frame_case (rsp.frame_case),
	.rsp_frame_end  (rsp.frame_end),
	.cfg_we         (cfg_we),
	.cfg_idx        (cfg_idx),
	.cfg_stereo_bit (cfg_data[0])
);

/* tb/sv/afr_ring_scoreboard.sv */
// ----------------------------------------------------------------------------
// afr_ring_scoreboard
// Watches the request, result and register ports of the frame ring, keeps
// its own copy of the ring state and compares every result word it sees.
// ----------------------------------------------------------------------------
module afr_ring_scoreboard import afr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	afr_in_if                    req,
	afr_out_if                   rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   errors,
	output int                   outstanding
);

	typedef struct packed {
		logic [SMP_W-1:0] left;
		logic [SMP_W-1:0] right;
		logic [1:0]       fcase;
		logic             fend;
	} play_word_t;

	play_word_t expected_words[$];

	logic [ENT_W-1:0]  ring_mem [FS_DEPTH];
	logic [ENT_W-1:0]  history [MAX_FRAME];
	logic [FC_W-1:0]   wr_frames;
	logic [FC_W-1:0]   rd_frames;
	logic [LEN_W-1:0]  fill;
	logic [LEN_W-1:0]  out_pos;
	case_t             play_case;
	logic [SLOT_W-1:0] old_slot;
	logic [SLOT_W-1:0] new_slot;
	logic [FADE_W-1:0] fade;
	logic [LEN_W-1:0]  len_reg;
	logic [STEP_W-1:0] step_reg;
	logic              stereo_reg;
	int                err_cnt;

	function automatic int frame_words();
		int n;
		n = int'({len_reg[LEN_W-1:2], 2'b00});
		if (n < 4) n = 4;
		if (n > MAX_FRAME) n = MAX_FRAME & ~3;
		return n;
	endfunction

	// floor of the weighted sum over 256, clipped to 16 bits signed
	function automatic logic [SMP_W-1:0] blend(input logic signed [SMP_W-1:0] a,
			input logic signed [SMP_W-1:0] b, input int w2);
		longint acc;
		acc = longint'(a) * longint'(256 - w2) + longint'(b) * longint'(w2);
		acc = acc >>> 8;
		if (acc > 32767) acc = 32767;
		else if (acc < -32768) acc = -32768;
		return acc[SMP_W-1:0];
	endfunction

	task automatic take_request(input mode_t m, input sample_t l, input sample_t r);
		int               n;
		int               p;
		int               w2;
		logic [ENT_W-1:0] ent;
		logic [ENT_W-1:0] a;
		logic [ENT_W-1:0] b;
		logic signed [FC_W-1:0] gap;
		logic [FC_W-1:0]  last;
		play_word_t       w;
		n = frame_words();
		case (m)
			MODE_WRITE: begin
				ring_mem[int'(wr_frames % FRAME_SLOTS) * MAX_FRAME + int'(fill) % MAX_FRAME] =
					{stereo_reg ? r : 16'h0000, l};
				fill = fill + 1'b1;
				if (fill >= n) begin
					fill = '0;
					wr_frames = wr_frames + 1'b1;
				end
			end
			MODE_RESTART: begin
				wr_frames = '0;
				rd_frames = '0;
				fill = '0;
				out_pos = '0;
				fade = '0;
			end
			MODE_READ: begin
				if (out_pos >= n) out_pos = '0;
				p = int'(out_pos);
				// latch the case for the whole frame at its first word
				if (p == 0) begin
					gap = wr_frames - rd_frames;
					fade = '0;
					if (gap <= 0) begin
						play_case = CASE_MIRROR;
					end else if (gap <= 3) begin
						play_case = CASE_COPY;
						old_slot = SLOT_W'(rd_frames % FRAME_SLOTS);
						rd_frames = rd_frames + 1'b1;
					end else begin
						play_case = CASE_FADE;
						old_slot = SLOT_W'(rd_frames % FRAME_SLOTS);
						last = wr_frames - 1'b1;
						new_slot = SLOT_W'(last % FRAME_SLOTS);
						rd_frames = wr_frames;
					end
				end
				a = ring_mem[int'(old_slot) * MAX_FRAME + p];
				b = ring_mem[int'(new_slot) * MAX_FRAME + p];
				case (play_case)
					CASE_MIRROR: ent = (p < n / 2) ? history[n - 1 - p] : history[p];
					CASE_COPY:   ent = a;
					default: begin
						if (p < n / 4) begin
							ent = a;
						end else if (p < n / 4 + n / 2) begin
							w2 = int'(fade >> 8);
							ent = {blend(a[31:16], b[31:16], w2), blend(a[15:0], b[15:0], w2)};
							fade = fade + FADE_W'(step_reg);
						end else begin
							ent = b;
						end
					end
				endcase
				if (!stereo_reg) ent[31:16] = '0;
				history[p] = ent;
				w.left = ent[15:0];
				w.right = ent[31:16];
				w.fcase = play_case;
				w.fend = (p == n - 1);
				expected_words.push_back(w);
				out_pos = LEN_W'(p + 1);
				if (out_pos >= n) out_pos = '0;
			end
			default: ;
		endcase
	endtask

	task automatic check_result();
		play_word_t w;
		if (expected_words.size() == 0) begin
			$error("result word with nothing expected: left_out %0d right_out %0d",
				rsp.left_out, rsp.right_out);
			err_cnt++;
		end else begin
			w = expected_words.pop_front();
			if (rsp.left_out !== w.left) begin
				$error("left_out: expected %0d, got %0d", $signed(w.left), rsp.left_out);
				err_cnt++;
			end
			if (rsp.right_out !== w.right) begin
				$error("right_out: expected %0d, got %0d", $signed(w.right), rsp.right_out);
				err_cnt++;
			end
			if (rsp.frame_case !== w.fcase) begin
				$error("frame_case: expected %0d, got %0d", w.fcase, rsp.frame_case);
				err_cnt++;
			end
			if (rsp.frame_end !== w.fend) begin
				$error("frame_end: expected %0d, got %0d", w.fend, rsp.frame_end);
				err_cnt++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (ring_mem[i]) ring_mem[i] = '0;
			foreach (history[i]) history[i] = '0;
			wr_frames = '0;
			rd_frames = '0;
			fill = '0;
			out_pos = '0;
			play_case = CASE_MIRROR;
			old_slot = '0;
			new_slot = '0;
			fade = '0;
			len_reg = FRAME_LENGTH_RST;
			step_reg = MIX_STEP_RST;
			stereo_reg = 1'b1;
			expected_words.delete();
			err_cnt = 0;
		end else begin
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) check_result();
			if (cfg_we === 1'b1) begin
				case (cfg_idx)
					REG_FRAME_LENGTH: len_reg = cfg_data[LEN_W-1:0];
					REG_MIX_STEP:     step_reg = cfg_data[STEP_W-1:0];
					REG_STEREO_MODE:  stereo_reg = cfg_data[0];
					default: ;
				endcase
			end
			if (req.valid === 1'b1 && req.ready === 1'b1)
				take_request(req.mode, req.left_in, req.right_in);
		end
		errors <= err_cnt;
		outstanding <= expected_words.size();
	end

endmodule

/* tb/sv/audio_frame_ring_with_crossfade_top_tb.sv */
// ----------------------------------------------------------------------------
// audio_frame_ring_with_crossfade_top_tb
// Drives write, read, restart and idle words into the frame ring under a run
// of register settings and idling patterns; a scoreboard beside the block
// predicts every result word and reports mismatches.
// ----------------------------------------------------------------------------
module audio_frame_ring_with_crossfade_top_tb;
	import afr_pkg::*;

	// index with no register behind it; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
	localparam sample_t S_MAX     = 16'sh7FFF;
	localparam sample_t S_MIN     = 16'sh8000;
	localparam int      LONG_HOLD = 400;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	int errors;
	int outstanding;
	int tx_idle_pct;
	int rx_stall_pct;
	int words_left;
	bit long_hold_req;

	afr_in_if  req ();
	afr_out_if rsp ();

	audio_frame_ring_with_crossfade_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	afr_ring_scoreboard scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run, clearing pass included.
	initial begin
		#1_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Result side. Stall at the current rate, or hold off for a long stretch
	// when asked, so that the block backs up and drops its request ready.
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				rsp.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				rsp.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	// Mostly random, with a fair share of full-scale values so that the
	// crossfade saturates once the weight passes unity.
	function automatic sample_t any_sample();
		sample_t s;
		case ($urandom_range(0, 9))
			0:       s = S_MAX;
			1:       s = S_MIN;
			default: s = sample_t'($urandom);
		endcase
		return s;
	endfunction

	// Offer one word and hold it until the block takes it. Idle gaps go in
	// front, each drawn against the idle rate, so valid never drops between
	// two words unless a gap is actually taken.
	task automatic send_word(input mode_t m, input sample_t l, input sample_t r);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= m;
		req.left_in <= l;
		req.right_in <= r;
		do @(posedge clk); while (req.ready !== 1'b1);
		if (m != MODE_NOP) words_left--;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= CFG_W'(value);
		@(posedge clk);
	endtask

	// Let the count of the last accepted word land, wait for the last
	// result, then let any write still in the pipe retire before the
	// registers move.
	task automatic settle();
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_regs(input int len, input int step, input int stereo);
		write_reg(REG_FRAME_LENGTH, len);
		write_reg(REG_MIX_STEP, step);
		write_reg(REG_STEREO_MODE, stereo);
		cfg_we <= 1'b0;
	endtask

	// Mostly whole frames of writes and reads, so the frame distance walks
	// through mirror, copy and crossfade; the odd word over a frame edge,
	// restarts, idle codes and lone words make up the noise.
	task automatic play_random(input int frame_len);
		int pick;
		int n;
		while (words_left > 0) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				n = $urandom_range(1, 5) * frame_len;
				if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 3);
				for (int i = 0; i < n && words_left > 0; i++)
					send_word(MODE_WRITE, any_sample(), any_sample());
			end else if (pick < 88) begin
				n = $urandom_range(1, 2) * frame_len;
				if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 3);
				for (int i = 0; i < n && words_left > 0; i++)
					send_word(MODE_READ, any_sample(), any_sample());
			end else if (pick < 92) begin
				send_word(MODE_RESTART, any_sample(), any_sample());
			end else if (pick < 95) begin
				send_word(MODE_NOP, any_sample(), any_sample());
			end else begin
				send_word($urandom_range(0, 1) ? MODE_READ : MODE_WRITE,
					any_sample(), any_sample());
			end
		end
	endtask

	// One phase: quiet the block, load the registers, set the idling rates
	// and play. The frame position is left as it is, so a new length often
	// lands in the middle of a frame.
	task automatic run_phase(input int len, input int step, input int stereo,
			input int frame_len, input int tx, input int rx, input int budget,
			input bit hold);
		settle();
		set_regs(len, step, stereo);
		tx_idle_pct = tx;
		rx_stall_pct = rx;
		if (hold) long_hold_req = 1'b1;
		words_left = budget;
		play_random(frame_len);
		req.valid <= 1'b0;
	endtask

	initial begin
		int wait_cycles;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_FRAME_LENGTH;
		cfg_data = '0;
		req.valid = 1'b0;
		req.mode = MODE_NOP;
		req.left_in = '0;
		req.right_in = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		long_hold_req = 1'b0;
		words_left = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A length of three rounds up to the shortest frame of
		// four words; the unused index gets all ones and must be ignored.
		write_reg(REG_UNUSED, (1 << CFG_W) - 1);
		set_regs(3, 16384, 1);

		// four frames, mostly of full-scale values: the first read frame is a
		// crossfade from the oldest frame to the newest
		for (int f = 0; f < 4; f++) begin
			send_word(MODE_WRITE, S_MAX, S_MIN);
			send_word(MODE_WRITE, S_MIN, S_MAX);
			send_word(MODE_WRITE, (f == 0) ? S_MAX : S_MIN, (f == 0) ? S_MAX : S_MIN);
			send_word(MODE_WRITE, 16'sh0000, 16'shFFFF);
		end
		repeat (4) send_word(MODE_READ, '0, '0);
		// nothing pending now: mirror the crossfade output back to front
		repeat (2) send_word(MODE_READ, '0, '0);
		send_word(MODE_RESTART, S_MAX, S_MIN);
		send_word(MODE_NOP, S_MIN, S_MAX);
		// counters cleared, stored samples kept: a fresh mirror frame
		send_word(MODE_READ, '0, '0);
		req.valid <= 1'b0;

		// Random phases: length, step, stereo, words per frame, sender idle
		// and receiver stall rates, word budget, long hold-off.
		run_phase(8,    8192,  1, 8,    0,  0,  300, 1'b0);
		run_phase(16,   16384, 1, 16,   49, 0,  300, 1'b0);
		run_phase(12,   0,     0, 12,   0,  49, 250, 1'b0);
		run_phase(2047, 32767, 1, 1024, 34, 34, 80,  1'b0);
		run_phase(32,   4096,  0, 32,   34, 34, 250, 1'b0);
		run_phase(5,    16384, 1, 4,    0,  0,  200, 1'b1);
		run_phase(64,   1024,  1, 64,   49, 0,  200, 1'b0);

		// Drain, with a bound, then give late or extra words time to show.
		@(posedge clk);
		wait_cycles = 0;
		while (outstanding != 0 && wait_cycles < 50000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (16) @(posedge clk);
		if (outstanding != 0) $error("%0d expected result words never arrived", outstanding);

		if (errors == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/afr_pkg.sv
rtl/afr_in_if.sv
rtl/afr_out_if.sv
rtl/afr_ram.sv
rtl/audio_frame_ring_with_crossfade_top.sv
rtl/afr_checker.sv
tb/sv/afr_ring_scoreboard.sv
tb/sv/audio_frame_ring_with_crossfade_top_tb.sv
